@@ sv/ckbe_pkg.sv @@
`default_nettype none

package ckbe_pkg;

    localparam int STAGES      = 4;
    localparam int MAX_RESULTS = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam int SLOT_W  = $clog2(MAX_RESULTS);
    localparam int COUNT_W = $clog2(MAX_RESULTS + 1);

    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [COUNT_W-1:0] t_count;

    // register indexes
    localparam logic [2:0] REG_STAGE_COUNT   = 3'd0;
    localparam logic [2:0] REG_FIELD_KINDS   = 3'd1;
    localparam logic [2:0] REG_TAG_KINDS     = 3'd2;
    localparam logic [2:0] REG_TAG_VALUES    = 3'd3;
    localparam logic [2:0] REG_FIXED_LENGTHS = 3'd4;

    // field kinds
    localparam logic [1:0] KIND_FIXED   = 2'd0;
    localparam logic [1:0] KIND_ESCAPED = 2'd1;
    localparam logic [1:0] KIND_TAILING = 2'd2;
    localparam logic [1:0] KIND_OMITTED = 2'd3;

    // tag kinds
    localparam logic [1:0] TAG_NONE = 2'd0;
    localparam logic [1:0] TAG_ONE  = 2'd1;
    localparam logic [1:0] TAG_TWO  = 2'd2;

    localparam logic [7:0] BYTE_END = 8'd0;
    localparam logic [7:0] BYTE_ESC = 8'd1;

    typedef struct packed {
        logic [2:0]  stage_count;
        logic [7:0]  field_kinds;
        logic [7:0]  tag_kinds;
        logic [63:0] tag_values;
        logic [31:0] fixed_lengths;
    } t_cfg;

    // one classified item: the bytes it expands to and its end marks
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        t_count                      count;
        logic                        silent;
        logic                        recend;
        logic                        lenerr;
    } t_entry;

endpackage

`default_nettype wire

@@ sv/ckbe_front.sv @@
`default_nettype none

module ckbe_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ckbe_pkg::t_cfg  i_cfg,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [7:0]      i_key_byte,
    input  wire logic            i_has_byte,
    input  wire logic            i_key_last,
    input  wire logic            i_q_full,
    output logic                 o_push,
    output ckbe_pkg::t_entry     o_entry
);
    import ckbe_pkg::*;

    localparam logic [2:0] MAX_STAGES = 3'(STAGES);

    logic [1:0] r_stage, n_stage;
    logic [8:0] r_kcnt, n_kcnt;
    logic       accept;
    logic [1:0] sh;
    logic [1:0] kind;
    logic [1:0] tkind;
    logic [15:0] tval;
    logic [7:0] flen;
    logic [2:0] cnt;
    logic [8:0] kcnt_upd;
    t_entry     ent;
    t_count     pos;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    assign sh    = 2'(r_stage % STAGES);
    assign kind  = i_cfg.field_kinds[2*sh +: 2];
    assign tkind = i_cfg.tag_kinds[2*sh +: 2];
    assign tval  = i_cfg.tag_values[16*sh +: 16];
    assign flen  = i_cfg.fixed_lengths[8*sh +: 8];

    always_comb begin
        cnt = i_cfg.stage_count;
        if (cnt == 3'd0) begin
            cnt = 3'd1;
        end
        if (cnt > MAX_STAGES) begin
            cnt = MAX_STAGES;
        end
    end

    assign kcnt_upd = (i_has_byte && r_kcnt != 9'd511) ? r_kcnt + 9'd1 : r_kcnt;

    always_comb begin
        ent = '0;
        pos = '0;
        if (i_has_byte) begin
            if (kind == KIND_ESCAPED && (i_key_byte == BYTE_END || i_key_byte == BYTE_ESC)) begin
                ent.bytes[SLOT_W'(pos)] = BYTE_ESC;
                pos = pos + t_count'(1);
            end
            if (kind != KIND_OMITTED) begin
                ent.bytes[SLOT_W'(pos)] = i_key_byte;
                pos = pos + t_count'(1);
            end
        end
        if (i_key_last) begin
            if (kind == KIND_ESCAPED) begin
                ent.bytes[SLOT_W'(pos)] = BYTE_END;
                pos = pos + t_count'(1);
            end
            ent.lenerr = (kind == KIND_FIXED) && (kcnt_upd != {1'b0, flen});
            case (tkind)
                TAG_ONE: begin
                    ent.bytes[SLOT_W'(pos)] = tval[7:0];
                    pos = pos + t_count'(1);
                end
                TAG_TWO: begin
                    ent.bytes[SLOT_W'(pos)] = tval[15:8];
                    pos = pos + t_count'(1);
                    ent.bytes[SLOT_W'(pos)] = tval[7:0];
                    pos = pos + t_count'(1);
                end
                default: begin
                end
            endcase
            if (pos == '0) begin
                ent.silent = 1'b1;
                pos        = t_count'(1);
            end
            ent.recend = ({1'b0, r_stage} + 3'd1) >= cnt;
        end
        ent.count = pos;
    end

    assign o_entry = ent;
    assign o_push  = accept && (ent.count != '0);

    always_comb begin
        n_stage = r_stage;
        n_kcnt  = r_kcnt;
        if (accept) begin
            if (i_key_last) begin
                n_kcnt  = '0;
                n_stage = ent.recend ? 2'd0 : r_stage + 2'd1;
            end else begin
                n_kcnt = kcnt_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
            r_kcnt  <= '0;
        end else begin
            r_stage <= n_stage;
            r_kcnt  <= n_kcnt;
        end
    end

    ap_push_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> accept)
        else $error("push without an input transfer");
    ap_key_end_always_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_key_last |-> o_push)
        else $error("key end produced no entry");

endmodule

`default_nettype wire

@@ sv/ckbe_queue.sv @@
`default_nettype none

module ckbe_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire ckbe_pkg::t_entry  i_entry,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output ckbe_pkg::t_entry       o_entry
);
    import ckbe_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    t_entry           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    ap_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue overflow");
    ap_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue underflow");

endmodule

`default_nettype wire

@@ sv/ckbe_back.sv @@
`default_nettype none

module ckbe_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire ckbe_pkg::t_entry  i_entry,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [7:0]             o_out_byte,
    output logic                   o_byte_valid,
    output logic                   o_run_last,
    output logic                   o_record_end,
    output logic                   o_length_error,
    output logic [15:0]            o_record_length
);
    import ckbe_pkg::*;

    logic        r_valid, n_valid;
    t_slot       r_idx, n_idx;
    logic [15:0] r_bir, n_bir;
    logic [7:0]  r_out_byte;
    logic        r_byte_valid;
    logic        r_run_last;
    logic        r_record_end;
    logic        r_length_error;
    logic [15:0] r_record_length;

    logic        adv;
    logic        last_slot;
    logic [15:0] bir_upd;

    assign adv       = i_q_valid && (!r_valid || i_ready);
    assign last_slot = (t_count'(r_idx) == i_entry.count - t_count'(1));
    assign o_pop     = adv && last_slot;
    assign bir_upd   = (!i_entry.silent && r_bir != 16'hFFFF) ? r_bir + 16'd1 : r_bir;

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        n_bir   = r_bir;
        if (adv) begin
            n_valid = 1'b1;
            n_idx   = last_slot ? '0 : r_idx + t_slot'(1);
            n_bir   = (last_slot && i_entry.recend) ? 16'd0 : bir_upd;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
            r_bir   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
            r_bir   <= n_bir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_byte      <= i_entry.silent ? 8'd0 : i_entry.bytes[r_idx];
            r_byte_valid    <= !i_entry.silent;
            r_run_last      <= last_slot;
            r_record_end    <= last_slot && i_entry.recend;
            r_length_error  <= last_slot && i_entry.lenerr;
            r_record_length <= bir_upd;
        end
    end

    assign o_valid         = r_valid;
    assign o_out_byte      = r_out_byte;
    assign o_byte_valid    = r_byte_valid;
    assign o_run_last      = r_run_last;
    assign o_record_end    = r_record_end;
    assign o_length_error  = r_length_error;
    assign o_record_length = r_record_length;

    ap_marks_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_record_end || r_length_error) |-> r_run_last)
        else $error("end mark on a result that is not the last of its item");
    ap_silent_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_byte_valid |-> r_run_last && r_out_byte == 8'd0)
        else $error("malformed empty result");

endmodule

`default_nettype wire

@@ sv/composite_key_byte_encoder_core.sv @@
`default_nettype none

// channel    direction  handshake           payload
// input      in         i_valid / o_ready   i_key_byte, i_has_byte, i_key_last
// result     out        o_valid / i_ready   o_out_byte, o_byte_valid, o_run_last,
//                                           o_record_end, o_length_error, o_record_length
// config     in         i_cfg_wr_en         i_cfg_addr, i_cfg_wdata
//
// An input transfer is taken every cycle while the two-entry queue has room.
// The back end emits one result per cycle unless the output stalls; an item expands to
// 1 to 5 results (at least one, silent if empty); an escaped key byte gives 1 or 2.
// Synchronous active-low reset clears stage, byte counts, queue and output valid.
// A stalled result holds in the output register; the queue keeps the input side moving.

module composite_key_byte_encoder_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [63:0] i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_key_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_key_last,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_byte_valid,
    output logic             o_run_last,
    output logic             o_record_end,
    output logic             o_length_error,
    output logic [15:0]      o_record_length
);
    import ckbe_pkg::*;

    t_cfg   r_cfg, n_cfg;
    t_entry push_entry;
    t_entry head_entry;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_valid;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_STAGE_COUNT:   n_cfg.stage_count   = i_cfg_wdata[2:0];
                REG_FIELD_KINDS:   n_cfg.field_kinds   = i_cfg_wdata[7:0];
                REG_TAG_KINDS:     n_cfg.tag_kinds     = i_cfg_wdata[7:0];
                REG_TAG_VALUES:    n_cfg.tag_values    = i_cfg_wdata;
                REG_FIXED_LENGTHS: n_cfg.fixed_lengths = i_cfg_wdata[31:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg             <= '0;
            r_cfg.stage_count <= 3'd1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    ckbe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_key_byte (i_key_byte),
        .i_has_byte (i_has_byte),
        .i_key_last (i_key_last),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    ckbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    ckbe_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_entry         (head_entry),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_run_last      (o_run_last),
        .o_record_end    (o_record_end),
        .o_length_error  (o_length_error),
        .o_record_length (o_record_length)
    );

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import ckbe_pkg::*;

    localparam logic [1:0] TAG_UNKNOWN = 2'd3;
    localparam int         DRAIN_CYCLES = 30;

    typedef struct packed {
        logic [7:0] key_byte;
        logic       has_byte;
        logic       key_last;
    } t_key_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        run_last;
        logic        record_end;
        logic        length_error;
        logic [15:0] record_length;
    } t_enc_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [63:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_key_item   cur_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        run_last;
    logic        record_end;
    logic        length_error;
    logic [15:0] record_length;

    t_key_item   pending_keys[$];
    t_enc_byte   expected_bytes[$];
    t_enc_byte   item_bytes[$];

    // predictor state
    t_cfg        model_cfg;
    logic [1:0]  cur_stage = '0;
    logic [8:0]  key_count = '0;
    logic [15:0] rec_len = '0;

    int          gap_pct = 0;
    int          stall_pct = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          mismatch_count = 0;

    composite_key_byte_encoder_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_valid         (in_valid),
        .o_ready         (in_ready),
        .i_key_byte      (cur_item.key_byte),
        .i_has_byte      (cur_item.has_byte),
        .i_key_last      (cur_item.key_last),
        .o_valid         (out_valid),
        .i_ready         (out_ready),
        .o_out_byte      (out_byte),
        .o_byte_valid    (byte_valid),
        .o_run_last      (run_last),
        .o_record_end    (record_end),
        .o_length_error  (length_error),
        .o_record_length (record_length)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic void add_byte(logic valid, logic [7:0] b);
        t_enc_byte r;
        if (valid && rec_len != 16'hFFFF) rec_len++;
        r = '0;
        r.out_byte = valid ? b : 8'h00;
        r.byte_valid = valid;
        r.record_length = rec_len;
        item_bytes = {item_bytes, r};
    endfunction

    function automatic void encode_key_item(t_key_item it);
        int         sh;
        int         cnt;
        logic [1:0] kind;
        logic [1:0] tkind;
        logic [15:0] tval;
        logic [7:0] flen;
        logic       lenerr;
        logic       recend;
        sh = cur_stage;
        kind = model_cfg.field_kinds[2*sh +: 2];
        tkind = model_cfg.tag_kinds[2*sh +: 2];
        tval = model_cfg.tag_values[16*sh +: 16];
        flen = model_cfg.fixed_lengths[8*sh +: 8];
        cnt = model_cfg.stage_count;
        if (cnt < 1) cnt = 1;
        if (cnt > STAGES) cnt = STAGES;
        lenerr = 1'b0;
        recend = 1'b0;
        item_bytes.delete();
        if (it.has_byte) begin
            if (key_count != 9'd511) key_count++;
            if (kind == KIND_ESCAPED) begin
                if (it.key_byte == BYTE_END || it.key_byte == BYTE_ESC) add_byte(1'b1, BYTE_ESC);
                add_byte(1'b1, it.key_byte);
            end else if (kind != KIND_OMITTED) begin
                add_byte(1'b1, it.key_byte);
            end
        end
        if (it.key_last) begin
            if (kind == KIND_ESCAPED) add_byte(1'b1, BYTE_END);
            lenerr = (kind == KIND_FIXED) && (key_count != {1'b0, flen});
            if (tkind == TAG_ONE) begin
                add_byte(1'b1, tval[7:0]);
            end else if (tkind == TAG_TWO) begin
                add_byte(1'b1, tval[15:8]);
                add_byte(1'b1, tval[7:0]);
            end
            if (item_bytes.size() == 0) add_byte(1'b0, 8'h00);
            recend = (sh + 1 >= cnt);
        end
        if (item_bytes.size() > 0) begin
            item_bytes[item_bytes.size()-1].run_last = 1'b1;
            item_bytes[item_bytes.size()-1].record_end = recend;
            item_bytes[item_bytes.size()-1].length_error = lenerr;
        end
        foreach (item_bytes[k]) expected_bytes = {expected_bytes, item_bytes[k]};
        if (it.key_last) begin
            key_count = '0;
            if (recend) begin
                cur_stage = '0;
                rec_len = '0;
            end else begin
                cur_stage = cur_stage + 2'd1;
            end
        end
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // input side
    always @(posedge i_clk) begin : key_driver
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_valid && in_ready) encode_key_item(cur_item);
            if (!in_valid || in_ready) begin
                if (gap_left == 0 && gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
                    gap_left = $urandom_range(1, 9);
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_keys.size() > 0) begin
                    cur_item <= pending_keys.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output side
    always @(posedge i_clk) begin : byte_monitor
        t_enc_byte want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("result transfer with nothing expected: byte %0h", out_byte);
                    mismatch_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    check_field("out_byte", want.out_byte, out_byte);
                    check_field("byte_valid", want.byte_valid, byte_valid);
                    check_field("run_last", want.run_last, run_last);
                    check_field("record_end", want.record_end, record_end);
                    check_field("length_error", want.length_error, length_error);
                    check_field("record_length", want.record_length, record_length);
                end
            end
            if (stall_left == 0 && stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
                stall_left = $urandom_range(1, 9);
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic push_item(logic [7:0] b, logic has, logic last);
        t_key_item it;
        it.key_byte = b;
        it.has_byte = has;
        it.key_last = last;
        pending_keys = {pending_keys, it};
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 5))
            0: return BYTE_END;
            1: return BYTE_ESC;
            2: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_key(int len);
        logic tail_byte;
        tail_byte = 1'($urandom_range(0, 1));
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0) push_item(rand_byte(), 1'b0, 1'b0);
            push_item(rand_byte(), 1'b1, (i == len - 1) && tail_byte);
        end
        if (len == 0 || !tail_byte) push_item(rand_byte(), 1'b0, 1'b1);
    endtask

    task automatic wait_drained();
        while (pending_keys.size() != 0 || in_valid || expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_STAGE_COUNT:   model_cfg.stage_count = val[2:0];
            REG_FIELD_KINDS:   model_cfg.field_kinds = val[7:0];
            REG_TAG_KINDS:     model_cfg.tag_kinds = val[7:0];
            REG_TAG_VALUES:    model_cfg.tag_values = val;
            REG_FIXED_LENGTHS: model_cfg.fixed_lengths = val[31:0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_all(logic [2:0] sc, logic [7:0] fk, logic [7:0] tk, logic [63:0] tv,
                             logic [31:0] fl);
        write_reg(REG_STAGE_COUNT, {61'd0, sc});
        write_reg(REG_FIELD_KINDS, {56'd0, fk});
        write_reg(REG_TAG_KINDS, {56'd0, tk});
        write_reg(REG_TAG_VALUES, tv);
        write_reg(REG_FIXED_LENGTHS, {32'd0, fl});
    endtask

    initial begin : stimulus
        int target;
        model_cfg = '0;
        model_cfg.stage_count = 3'd1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        gap_pct = 20;
        stall_pct = 20;

        // reset settings: one fixed stage of length 0
        push_item(8'h00, 1'b1, 1'b1);
        push_item(8'hA5, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'hFF, 1'b1, 1'b0);
        push_item(8'h7E, 1'b1, 1'b1);
        wait_drained();

        write_all(3'd4, {KIND_OMITTED, KIND_TAILING, KIND_ESCAPED, KIND_FIXED},
                  {TAG_UNKNOWN, TAG_TWO, TAG_ONE, TAG_NONE},
                  64'h1234_FF00_00AB_0000, 32'h0000_0002);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'hFF, 1'b1, 1'b1);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'h01, 1'b1, 1'b0);
        push_item(8'h02, 1'b1, 1'b0);
        push_item(8'hC3, 1'b0, 1'b1);
        push_item(8'h80, 1'b1, 1'b0);
        push_item(8'h7F, 1'b1, 1'b1);
        push_item(8'h55, 1'b1, 1'b0);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b1);
        // wrong fixed length, empty escaped key, omitted key ending on a byte
        push_item(8'h10, 1'b1, 1'b1);
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'hFF, 1'b1, 1'b1);
        push_item(8'h01, 1'b1, 1'b1);
        push_item(8'h22, 1'b1, 1'b0);
        push_item(8'h33, 1'b1, 1'b1);
        push_item(8'h44, 1'b1, 1'b1);
        wait_drained();
        // stage count shrinks mid record
        write_reg(REG_STAGE_COUNT, 64'd1);
        push_item(8'h66, 1'b1, 1'b1);
        wait_drained();

        for (int p = 0; p < 10; p++) begin
            case (p)
                0: write_all(3'd0, 8'h00, 8'h00, 64'd0, 32'd0);
                1: write_all(3'd7, 8'hFF, 8'hFF, '1, '1);
                2: write_all(3'd4, 8'h55, 8'hAA, '1, 32'hFFFF_FFFF);
                default: begin
                    write_all(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), {$urandom, $urandom},
                              ($urandom_range(0, 3) == 0) ? 32'($urandom) :
                              {8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)),
                               8'($urandom_range(0, 6)), 8'($urandom_range(0, 6))});
                end
            endcase
            if (p % 4 == 3) begin
                gap_pct = 0;
                stall_pct = 0;
            end else begin
                gap_pct = $urandom_range(10, 40);
                stall_pct = $urandom_range(10, 40);
            end
            target = pending_keys.size() + 25;
            while (pending_keys.size() < target) queue_key($urandom_range(0, 6));
            wait_drained();
        end

        gap_pct = 0;
        stall_pct = 0;
        // fixed key longer than its configured length
        write_all(3'd1, {4{KIND_FIXED}}, {4{TAG_NONE}}, 64'd0, 32'd3);
        for (int i = 0; i < 12; i++) push_item(rand_byte(), 1'b1, i == 11);
        wait_drained();

        // escaped bytes back to back with two-byte tags
        write_all(3'd1, {4{KIND_ESCAPED}}, {4{TAG_TWO}}, 64'hBEEF, 32'd0);
        for (int i = 0; i < 20; i++) push_item(8'($urandom_range(0, 1)), 1'b1, 1'b0);
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'h42, 1'b1, 1'b1);
        wait_drained();

        if (mismatch_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
sv/ckbe_pkg.sv
sv/ckbe_front.sv
sv/ckbe_queue.sv
sv/ckbe_back.sv
sv/composite_key_byte_encoder_core.sv
test/tb_top.sv
